@@ hdl/dhkv_pkg.sv @@
`default_nettype none
package dhkv_pkg;
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [63:0] OFFSET_START = 64'd14695981039346656037;
    localparam logic [63:0] OFFSET_STEP  = 64'd3300246481284065416;

    // register index of the table size
    localparam logic [1:0] REG_TABLE_LOG2 = 2'd0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // classified word passed from hash front to probe back
    typedef struct packed {
        op_t          op;
        logic [63:0]  key;
        logic [3:0]   len;
        logic [31:0]  value;
        logic [63:0]  h_start;
        logic [63:0]  h_step;
    } job_t;
endpackage
`default_nettype wire

@@ hdl/dhkv_front.sv @@
`default_nettype none
module dhkv_front
    import dhkv_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_op,
    input  wire logic [63:0] in_key,
    input  wire logic [3:0]  in_len,
    input  wire logic [31:0] in_value,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_DONE = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    job_t        job_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  len_c;
    logic [63:0] kmask;
    logic [7:0]  byte_c;

    // multiply by the FNV prime (2^40 + 0x1B3) as shifts and adds
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // clamp length and mask key bytes past it
    always_comb begin
        len_c = (in_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : in_len;
        kmask = (len_c >= 4'd8) ? '1 : ((64'd1 << {len_c, 3'b000}) - 64'd1);
        byte_c = job_reg.key[{idx_reg[2:0], 3'b000} +: 8];
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_DONE);
    assign job       = job_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_HASH;
            F_HASH: if (idx_reg >= job_reg.len) state_next = F_DONE;
            F_DONE: if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // advance both hashes one byte a cycle
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && in_valid) begin
            job_reg.op      <= op_t'(in_op);
            job_reg.key     <= in_key & kmask;
            job_reg.len     <= len_c;
            job_reg.value   <= in_value;
            job_reg.h_start <= OFFSET_START;
            job_reg.h_step  <= OFFSET_STEP;
            idx_reg         <= 4'd0;
        end else if (state_reg == F_HASH && idx_reg < job_reg.len) begin
            job_reg.h_start <= fnv_mul(job_reg.h_start ^ {56'd0, byte_c});
            job_reg.h_step  <= fnv_mul(job_reg.h_step ^ {56'd0, byte_c});
            idx_reg         <= idx_reg + 4'd1;
        end
    end
endmodule
`default_nettype wire

@@ hdl/dhkv_queue.sv @@
`default_nettype none
module dhkv_queue
    import dhkv_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);
    job_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

@@ hdl/dhkv_back.sv @@
`default_nettype none
module dhkv_back
    import dhkv_pkg::*;
#(
    parameter int MAX_SLOTS_LOG2 = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [3:0]  table_log2,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  job_t             job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_status,
    output logic [31:0]      out_value
);
    localparam int N  = 1 << MAX_SLOTS_LOG2;
    localparam int AW = MAX_SLOTS_LOG2;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_READ  = 5'b00010,
        B_CHECK = 5'b00100,
        B_WRITE = 5'b01000,
        B_OUT   = 5'b10000
    } bstate_t;

    bstate_t      state_reg, state_next;
    logic [N-1:0] used_reg;
    logic         del_mem [N];
    logic [63:0]  key_mem [N];
    logic [3:0]   len_mem [N];
    logic [31:0]  val_mem [N];
    logic [63:0]  rkey_reg;
    logic [3:0]   rlen_reg;
    logic [31:0]  rval_reg;
    logic         rused_reg, rdel_reg;
    logic [AW:0]  count_reg;
    job_t         job_reg;
    logic [AW-1:0] mask_reg, slot_reg, step_reg;
    logic [AW:0]  probe_reg;
    logic [AW:0]  size_c;
    logic [AW-1:0] mask_c;
    logic [3:0]   lg_c;
    logic [2:0]   status_reg;
    logic [31:0]  vout_reg;
    logic         wr_new_reg;
    logic         hit;

    // clamp table size
    always_comb begin
        lg_c = (table_log2 < 4'd1) ? 4'd1 :
               ((int'(table_log2) > MAX_SLOTS_LOG2) ? 4'(MAX_SLOTS_LOG2) : table_log2);
        size_c = (AW+1)'(1) << lg_c;
        mask_c = AW'(size_c - (AW+1)'(1));
        hit = rused_reg && !rdel_reg && rlen_reg == job_reg.len && rkey_reg == job_reg.key;
    end

    assign job_ready  = (state_reg == B_IDLE);
    assign out_valid  = (state_reg == B_OUT);
    assign out_status = status_reg;
    assign out_value  = vout_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_READ;
            B_READ:  state_next = B_CHECK;
            B_CHECK: begin
                if (job_reg.op == OP_NONE) state_next = B_OUT;
                else if (job_reg.op == OP_INSERT) begin
                    if (!rused_reg || rdel_reg || hit) state_next = B_WRITE;
                    else if (probe_reg + (AW+1)'(1) >= size_c) state_next = B_OUT;
                    else state_next = B_READ;
                end else begin
                    if (!rused_reg || hit) state_next = B_WRITE;
                    else if (probe_reg + (AW+1)'(1) >= size_c) state_next = B_OUT;
                    else state_next = B_READ;
                end
            end
            B_WRITE: state_next = B_OUT;
            B_OUT:   if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            used_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_WRITE && status_reg == ST_INSERTED) begin
                used_reg[slot_reg] <= 1'b1;
                count_reg <= count_reg + (AW+1)'(1);
            end else if (state_reg == B_WRITE && status_reg == ST_REMOVED) begin
                if (count_reg != '0) count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    // read slot contents registered
    always_ff @(posedge aclk) begin
        if (state_reg == B_READ) begin
            rkey_reg  <= key_mem[slot_reg];
            rlen_reg  <= len_mem[slot_reg];
            rval_reg  <= val_mem[slot_reg];
            rused_reg <= used_reg[slot_reg];
            rdel_reg  <= del_mem[slot_reg];
        end
    end

    // tombstone flags matter only for used slots, so they need no reset
    always_ff @(posedge aclk) begin
        if (state_reg == B_WRITE && wr_new_reg) begin
            key_mem[slot_reg] <= job_reg.key;
            len_mem[slot_reg] <= job_reg.len;
        end
        if (state_reg == B_WRITE &&
            (status_reg == ST_INSERTED || status_reg == ST_REPLACED)) begin
            val_mem[slot_reg] <= job_reg.value;
        end
        if (state_reg == B_WRITE && status_reg == ST_INSERTED) begin
            del_mem[slot_reg] <= 1'b0;
        end else if (state_reg == B_WRITE && status_reg == ST_REMOVED) begin
            del_mem[slot_reg] <= 1'b1;
        end
    end

    // probe walk and result decision
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: if (job_valid) begin
                job_reg    <= job;
                mask_reg   <= mask_c;
                slot_reg   <= job.h_start[AW-1:0] & mask_c;
                step_reg   <= (job.h_step[AW-1:0] & mask_c) | AW'(1);
                probe_reg  <= '0;
                status_reg <= ST_NOT_FOUND;
                vout_reg   <= '0;
                wr_new_reg <= 1'b0;
            end
            B_CHECK: begin
                if (job_reg.op == OP_INSERT) begin
                    if (!rused_reg || rdel_reg) begin
                        if (count_reg < size_c) begin
                            status_reg <= ST_INSERTED;
                            vout_reg   <= job_reg.value;
                            wr_new_reg <= 1'b1;
                        end else begin
                            status_reg <= ST_FULL;
                        end
                    end else if (hit) begin
                        status_reg <= ST_REPLACED;
                        vout_reg   <= rval_reg;
                    end else begin
                        status_reg <= ST_FULL;
                    end
                end else if (job_reg.op != OP_NONE && hit) begin
                    status_reg <= (job_reg.op == OP_SEARCH) ? ST_FOUND : ST_REMOVED;
                    vout_reg   <= (job_reg.op == OP_SEARCH) ? rval_reg : 32'd0;
                end
                // hold the slot when it is about to be written
                if (state_next != B_WRITE) slot_reg <= (slot_reg + step_reg) & mask_reg;
                probe_reg <= probe_reg + (AW+1)'(1);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/double_hash_key_value_table.sv @@
`default_nettype none
// channel | ports                                    | accepted when
// input   | s_valid s_ready s_opcode s_key_bytes ... | s_valid && s_ready
// result  | m_valid m_ready m_status m_value_out     | m_valid && m_ready
// config  | APB psel penable pwrite paddr pwdata     | psel&&penable&&pwrite
// Front hashes one key byte a cycle and holds one word at a time.
// Back takes the word, reads and checks each slot visited, has a write step unless
// the op is a no-op or the probe runs out, and presents the result; a two-word
// queue lets items overlap. Reset clears the used flags at once; no clearing pass.
// A stalled m_ready holds the back, and the queue then fills and stalls the front.
module double_hash_key_value_table
    import dhkv_pkg::*;
#(
    parameter int MAX_SLOTS_LOG2 = 8,
    parameter int MAX_KEY_BYTES  = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [63:0] s_key_bytes,
    input  wire logic [3:0]  s_key_length,
    input  wire logic [31:0] s_new_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_value_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [3:0] log2_reg;
    job_t       fjob, bjob;
    logic       fvalid, fready, bvalid, bready;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TABLE_LOG2) ? {28'd0, log2_reg} : 32'd0;

    // hold the size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg <= 4'd8;
        end else if (psel && penable && pwrite && paddr == REG_TABLE_LOG2) begin
            log2_reg <= pwdata[3:0];
        end
    end

    dhkv_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_op(s_opcode),
        .in_key(s_key_bytes), .in_len(s_key_length), .in_value(s_new_value),
        .job_valid(fvalid), .job_ready(fready), .job(fjob)
    );

    dhkv_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fvalid), .wr_ready(fready), .wr_data(fjob),
        .rd_valid(bvalid), .rd_ready(bready), .rd_data(bjob)
    );

    dhkv_back #(.MAX_SLOTS_LOG2(MAX_SLOTS_LOG2)) u_back (
        .aclk, .aresetn, .table_log2(log2_reg),
        .job_valid(bvalid), .job_ready(bready), .job(bjob),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_status(m_status), .out_value(m_value_out)
    );

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_FULL) else $error("bad status");
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_NOT_FOUND || m_status == ST_REMOVED ||
                     m_status == ST_FULL))
        |-> m_value_out == 32'd0) else $error("nonzero value");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_status)) else $error("drop");
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import dhkv_pkg::*;

    localparam int  STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [63:0] s_key_bytes = '0;
    logic [3:0]  s_key_length = '0;
    logic [31:0] s_new_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_value_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    double_hash_key_value_table uut (.*);

    // shadow table state
    logic        tbl_used [256];
    logic        tbl_dead [256];
    logic [63:0] tbl_key [256];
    logic [3:0]  tbl_len [256];
    logic [31:0] tbl_val [256];
    int          live_count;
    logic [3:0]  size_log2;

    answer_t     pending_answers[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          receiver_hold = 0;
    bit          hold_on = 0;
    logic [63:0] key_pool[$];

    initial forever #4 aclk = ~aclk;

    function automatic logic [63:0] fnv_hash(logic [63:0] h, logic [63:0] k, int n);
        for (int b = 0; b < n; b++) begin
            h = h ^ {56'd0, k[8*b +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // compute the answer for one word and update the shadow table
    function automatic answer_t table_lookup(logic [1:0] op, logic [63:0] kb,
                                            logic [3:0] klen, logic [31:0] nv);
        answer_t     a;
        int          n, lg, sz, start, stride, s;
        logic [63:0] k, msk;
        a.status = ST_NOT_FOUND;
        a.value  = '0;
        n  = (klen > 8) ? 8 : int'(klen);
        lg = (size_log2 < 1) ? 1 : (size_log2 > 8) ? 8 : int'(size_log2);
        sz = 1 << lg;
        msk = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        k = kb & msk;
        start  = int'(fnv_hash(OFFSET_START, k, n) & (sz - 1));
        stride = int'(fnv_hash(OFFSET_STEP, k, n) & (sz - 1)) | 1;
        if (op == OP_INSERT) begin
            a.status = ST_FULL;
            for (int i = 0; i < sz; i++) begin
                s = (start + i * stride) & (sz - 1);
                if (!tbl_used[s] || tbl_dead[s]) begin
                    if (live_count < sz) begin
                        tbl_used[s] = 1; tbl_dead[s] = 0;
                        tbl_key[s] = k; tbl_len[s] = 4'(n); tbl_val[s] = nv;
                        live_count++;
                        a.status = ST_INSERTED;
                        a.value = nv;
                    end
                    break;
                end
                if (tbl_len[s] == n && tbl_key[s] == k) begin
                    a.value = tbl_val[s];
                    tbl_val[s] = nv;
                    a.status = ST_REPLACED;
                    break;
                end
            end
        end else if (op == OP_SEARCH || op == OP_REMOVE) begin
            for (int i = 0; i < sz; i++) begin
                s = (start + i * stride) & (sz - 1);
                if (!tbl_used[s]) break;
                if (!tbl_dead[s] && tbl_len[s] == n && tbl_key[s] == k) begin
                    if (op == OP_SEARCH) begin
                        a.status = ST_FOUND;
                        a.value = tbl_val[s];
                    end else begin
                        tbl_dead[s] = 1;
                        if (live_count > 0) live_count--;
                        a.status = ST_REMOVED;
                    end
                    break;
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    // drop valid only when a real gap follows
    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
            : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // offer one word and hold it until accepted
    task automatic send_word(logic [1:0] op, logic [63:0] kb, logic [3:0] klen,
                             logic [31:0] nv);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_key_bytes <= kb;
        s_key_length <= klen;
        s_new_value <= nv;
        pending_answers.push_back(table_lookup(op, kb, klen, nv));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic gapped_word(logic [1:0] op, logic [63:0] kb, logic [3:0] klen,
                               logic [31:0] nv);
        send_word(op, kb, klen, nv);
        random_gap();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    task automatic write_table_log2(logic [3:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_TABLE_LOG2; pwdata <= {28'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        size_log2 = v;
    endtask

    function automatic logic [63:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        gapped_word(OP_SEARCH, '0, 4'd0, '0);
        gapped_word(OP_INSERT, '0, 4'd0, 32'hffff_ffff);
        gapped_word(OP_INSERT, '0, 4'd0, 32'h1234);
        gapped_word(OP_SEARCH, 64'hff, 4'd0, '0);
        gapped_word(OP_INSERT, '1, 4'd8, 32'h0);
        gapped_word(OP_SEARCH, '1, 4'd15, '0);
        gapped_word(OP_INSERT, 64'hdead_00ab, 4'd1, 32'h55);
        gapped_word(OP_SEARCH, 64'h00ab, 4'd1, '0);
        gapped_word(OP_SEARCH, 64'h00ab, 4'd2, '0);
        gapped_word(OP_REMOVE, 64'h77ab, 4'd1, '0);
        gapped_word(OP_REMOVE, 64'h77ab, 4'd1, '0);
        gapped_word(OP_SEARCH, 64'hab, 4'd1, '0);
        gapped_word(OP_INSERT, 64'hab, 4'd1, 32'haaaa_5555);
        gapped_word(OP_NONE, '1, 4'd8, '1);
        gapped_word(OP_REMOVE, 64'h5555_aaaa_5555_aaaa, 4'd7, '0);
        drain();
    endtask

    // tiny table: fill it, overflow, remove and reuse tombstones
    task automatic test_small_table(logic [3:0] lg);
        write_table_log2(lg);
        for (int i = 0; i < 6; i++)
            gapped_word(OP_INSERT, 64'(i * 7 + 1), 4'd2, $urandom());
        gapped_word(OP_REMOVE, 64'd1, 4'd2, '0);
        gapped_word(OP_SEARCH, 64'd8, 4'd2, '0);
        gapped_word(OP_INSERT, 64'd99, 4'd2, 32'h9);
        gapped_word(OP_INSERT, 64'd100, 4'd2, 32'h9);
        drain();
    endtask

    task automatic test_random(int count, logic [3:0] lg);
        logic [63:0] k;
        logic [1:0]  op;
        write_table_log2(lg);
        for (int i = 0; i < count; i++) begin
            k = pick_key();
            op = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
            if (op == OP_INSERT && key_pool.size() < 64) key_pool.push_back(k);
            gapped_word(op, k, 4'($urandom_range(0, 15)), $urandom());
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_on = 1;
        for (int i = 0; i < 20; i++)
            send_word(2'($urandom_range(0, 2)), pick_key(), 4'($urandom_range(1, 8)),
                      $urandom());
        drain();
    endtask

    // result receiver with random stalls
    always @(posedge aclk) begin
        if (receiver_hold > 0) begin
            receiver_hold <= receiver_hold - 1;
            m_ready <= 1'b0;
            if (receiver_hold == 1) hold_on <= 0;
        end else if (hold_on) begin
            receiver_hold <= 300;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 40) == 0);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", int'(m_status), 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", int'(m_status), int'(want.status));
                if (m_value_out !== want.value)
                    report_mismatch("value_out", int'(m_value_out), int'(want.value));
            end
        end
    end

    // watchdog on accepted words
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || receiver_hold > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[double_hash_key_value_table] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 256; i++) begin
            tbl_used[i] = 0; tbl_dead[i] = 0;
        end
        live_count = 0;
        size_log2 = 4'd8;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_small_table(4'd1);
        test_small_table(4'd0);
        test_random(150, 4'd3);
        test_random(200, 4'd8);
        test_random(100, 4'd15);
        test_random(120, 4'd5);
        test_random(80, 4'd2);
        if (error_count == 0)
            $display("[double_hash_key_value_table] OK");
        else
            $display("[double_hash_key_value_table] ERROR");
        $finish;
    end
endmodule

@@ files.f @@
hdl/dhkv_pkg.sv
hdl/dhkv_front.sv
hdl/dhkv_queue.sv
hdl/dhkv_back.sv
hdl/double_hash_key_value_table.sv
tb/sv/testbench.sv
